@@ rtl/core/ncf_pkg.sv @@
package ncf_pkg;
  localparam int SUM_W  = 40;
  localparam int DIST_W = 20;
  localparam int VAL_W  = 16;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic {OP_LOAD = 1'b0, OP_SAMPLE = 1'b1} op_t;
  typedef enum logic {KIND_ASSIGN = 1'b0, KIND_FIT = 1'b1} kind_t;

  // cell control, travels down the chain with the beat
  typedef struct packed {
    logic            vld;
    logic            clr;
    logic [VAL_W-1:0] val;
  } cell_ctl_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction
endpackage

@@ rtl/core/ncf_if.sv @@
interface ncf_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  center_index;
  logic [5:0]  feature_index;
  logic signed [15:0] value;
  logic        last_sample;
  modport source (output valid, operation, center_index, feature_index, value, last_sample,
                  input ready);
  modport sink (input valid, operation, center_index, feature_index, value, last_sample,
                output ready);
endinterface

interface ncf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  label;
  logic [19:0] distance;
  logic [19:0] fitness;
  logic        last;
  modport source (output valid, kind, label, distance, fitness, last, input ready);
  modport sink (input valid, kind, label, distance, fitness, last, output ready);
endinterface

@@ rtl/core/ncf_cell.sv @@
module ncf_cell import ncf_pkg::*; #(
  parameter int MAX_FEATURES = 64,
  parameter int FI_W = 6
) (
  input  logic                clk,
  input  logic                ld_we,
  input  logic [FI_W-1:0]     ld_fi,
  input  logic [VAL_W-1:0]    ld_val,
  input  logic [FI_W-1:0]     rd_fi,
  input  cell_ctl_t           ctl_in,
  output cell_ctl_t           ctl_out,
  output logic [SUM_W-1:0]    sum
);
  logic [VAL_W-1:0] mem [MAX_FEATURES];
  logic [VAL_W-1:0] cen_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic signed [VAL_W:0] d;
  logic [VAL_W:0] ad;
  logic [2*VAL_W+1:0] sq;

  // center store row, registered read
  always_ff @(posedge clk) begin
    if (ld_we) mem[ld_fi] <= ld_val;
    cen_r <= mem[rd_fi];
  end

  // squared difference and saturating accumulate
  always_comb begin
    d  = $signed({ctl_in.val[VAL_W-1], ctl_in.val}) - $signed({cen_r[VAL_W-1], cen_r});
    ad = d[VAL_W] ? (~d + 1'b1) : d;
    sq = {{(VAL_W+1){1'b0}}, ad} * {{(VAL_W+1){1'b0}}, ad};
    sum_nxt = ctl_in.clr ? '0 : sum_r;
    if (ctl_in.vld) sum_nxt = sat_add(sum_nxt, SUM_W'(sq));
  end

  always_ff @(posedge clk) begin
    if (ctl_in.vld || ctl_in.clr) sum_r <= sum_nxt;
    ctl_out <= ctl_in;
  end

  assign sum = sum_r;
endmodule

@@ rtl/core/ncf_sqrt.sv @@
module ncf_sqrt import ncf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  v,
  output logic              done,
  output logic [DIST_W-1:0] root
);
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [DIST_W-1:0] q_r, q_nxt;
  logic [4:0] cnt_r;
  logic busy_r;
  logic [DIST_W+1:0] trial;
  logic [DIST_W+1:0] part;

  // restoring square root, one result bit a cycle
  always_comb begin
    part  = (DIST_W+2)'(rem_r >> (2*cnt_r));
    trial = {q_r, 2'b01};
    rem_nxt = rem_r;
    q_nxt   = {q_r[DIST_W-2:0], 1'b0};
    if (part >= trial) begin
      rem_nxt = rem_r - (SUM_W'(trial) << (2*cnt_r));
      q_nxt   = {q_r[DIST_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= v;
        q_r    <= '0;
        cnt_r  <= 5'(DIST_W-1);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign root = q_r;
endmodule

@@ rtl/core/ncf_div.sv @@
module ncf_div import ncf_pkg::*; #(
  parameter int DEN_W = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [DIST_W-1:0] quo
);
  logic [SUM_W-1:0] q_r;
  logic [DEN_W:0] rem_r;
  logic [5:0] cnt_r;
  logic busy_r;
  logic [DEN_W:0] sh;

  // restoring division, one quotient bit a cycle
  assign sh = {rem_r[DEN_W-1:0], q_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= num;
        rem_r  <= '0;
        cnt_r  <= 6'(SUM_W-1);
      end else if (busy_r) begin
        if (sh >= {1'b0, den}) begin
          rem_r <= sh - {1'b0, den};
          q_r   <= {q_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[SUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign quo = (|q_r[SUM_W-1:DIST_W]) ? {DIST_W{1'b1}} : q_r[DIST_W-1:0];
endmodule

@@ rtl/core/nearest_center_fitness_top.sv @@
// channel | dir | beat contents
// in      | in  | operation, center_index, feature_index, value, last_sample
// out     | out | kind, label, distance, fitness, last
// cfg     | in  | cfg_we, cfg_index, cfg_data (num_centers, num_features)
// load beat: written straight into the center store. sample element: runs down the cell chain.
// last element adds a min scan over the centers,
// then a sqrt, and on the data set end a divide.
// input is held off while out waits.
// reset is synchronous, active low; the center store needs no clearing.
module nearest_center_fitness_top import ncf_pkg::*; #(
  parameter int MAX_CENTERS = 16,
  parameter int MAX_FEATURES = 64,
  parameter int MAX_SAMPLES = 1048576
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [6:0] cfg_data,
  ncf_in_if.sink   in_ch,
  ncf_out_if.source out_ch
);
  localparam int FI_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CI_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int CN_W = $clog2(MAX_CENTERS+1);
  localparam int CW   = $clog2(MAX_CENTERS+4);
  localparam int SC_W = $clog2(MAX_SAMPLES+1);

  typedef enum logic [2:0] {S_IDLE, S_CHAIN, S_SCAN, S_SQRT, S_OUT0, S_DIV, S_OUT1}
    state_t;
  state_t state_r;

  logic [4:0] nc_r;
  logic [6:0] nf_r;
  logic [CN_W-1:0] k;
  logic [6:0] nf;
  cell_ctl_t ctl [MAX_CENTERS+1];
  logic [SUM_W-1:0] sums [MAX_CENTERS];
  logic [FI_W-1:0] fi_r;
  logic [VAL_W-1:0] val_r;
  logic last_r, end_r, clr_r;
  logic [CW-1:0] cnt_r;
  logic [SUM_W-1:0] best_r, tot_r;
  logic [CI_W-1:0] bidx_r;
  logic [SC_W-1:0] scnt_r;
  logic sq_start, sq_done, dv_start, dv_done;
  logic [DIST_W-1:0] root, quo;
  logic acc;
  logic ok;

  // config registers, clamped on use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= 5'd16;
      nf_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) nc_r <= cfg_data[4:0];
      else nf_r <= cfg_data;
    end
  end
  assign k  = (nc_r == 0) ? CN_W'(1) : (32'(nc_r) > MAX_CENTERS) ? CN_W'(MAX_CENTERS)
            : CN_W'(nc_r);
  assign nf = (nf_r == 0) ? 7'd1 : (32'(nf_r) > MAX_FEATURES) ? 7'(MAX_FEATURES) : nf_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign ok  = (32'(in_ch.feature_index) < MAX_FEATURES);

  // head of the chain, asserted in the cycle after the store read address settles
  assign ctl[0].vld = (state_r == S_CHAIN) && (cnt_r == 1);
  assign ctl[0].clr = (state_r == S_CHAIN) && (cnt_r == 1) && clr_r;
  assign ctl[0].val = '0;

  // cell row, one per center
  for (genvar c = 0; c < MAX_CENTERS; c++) begin : g_cell
    logic we;
    cell_ctl_t ci;
    assign we = acc && (in_ch.operation == OP_LOAD) && ok
             && (32'(in_ch.center_index) == c);
    assign ci = '{vld: ctl[c].vld && (c < k) || 1'b0, clr: ctl[c].clr,
                  val: val_r};
    ncf_cell #(.MAX_FEATURES(MAX_FEATURES), .FI_W(FI_W)) u_cell (
      .clk(clk), .ld_we(we), .ld_fi(FI_W'(in_ch.feature_index)),
      .ld_val(in_ch.value), .rd_fi(fi_r), .ctl_in(ci), .ctl_out(ctl[c+1]),
      .sum(sums[c]));
  end

  ncf_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .v(best_r),
                   .done(sq_done), .root(root));
  ncf_div #(.DEN_W(SC_W)) u_div (.clk(clk), .rst_n(rst_n), .start(dv_start),
                 .num(tot_r), .den(scnt_r), .done(dv_done), .quo(quo));

  assign sq_start = (state_r == S_SCAN) && (32'(cnt_r) == MAX_CENTERS);
  assign dv_start = (state_r == S_OUT0) && out_ch.ready && last_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clr_r   <= 1'b1;
      tot_r   <= '0;
      scnt_r  <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (acc && (in_ch.operation == OP_SAMPLE) && ok) begin
            fi_r    <= FI_W'(in_ch.feature_index);
            val_r   <= in_ch.value;
            last_r  <= in_ch.last_sample;
            end_r   <= ({1'b0, in_ch.feature_index} == 7'(nf - 1'b1));
            cnt_r   <= '0;
            state_r <= S_CHAIN;
          end
        end
        S_CHAIN: begin
          cnt_r <= cnt_r + 1'b1;
          if (32'(cnt_r) == MAX_CENTERS + 1) begin
            clr_r <= 1'b0;
            cnt_r <= '0;
            state_r <= end_r ? S_SCAN : S_IDLE;
          end
        end
        S_SCAN: begin
          if (cnt_r == 0) begin
            best_r <= sums[0];
            bidx_r <= '0;
          end else if ((32'(cnt_r) < 32'(k)) && (sums[cnt_r[CI_W-1:0]] < best_r)) begin
            best_r <= sums[cnt_r[CI_W-1:0]];
            bidx_r <= cnt_r[CI_W-1:0];
          end
          cnt_r <= cnt_r + 1'b1;
          if (32'(cnt_r) == MAX_CENTERS) begin
            clr_r   <= 1'b1;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            tot_r <= sat_add(tot_r, SUM_W'(root));
            if (32'(scnt_r) < MAX_SAMPLES) scnt_r <= scnt_r + 1'b1;
            state_r <= S_OUT0;
          end
        end
        S_OUT0: begin
          if (out_ch.ready) state_r <= last_r ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (dv_done) state_r <= S_OUT1;
        end
        S_OUT1: begin
          if (out_ch.ready) begin
            tot_r   <= '0;
            scnt_r  <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] fit_r;
  always_ff @(posedge clk) begin
    if (sq_done) dist_r <= root;
    if (dv_done) fit_r <= quo;
  end

  // result beat
  assign out_ch.valid    = (state_r == S_OUT0) || (state_r == S_OUT1);
  assign out_ch.kind     = (state_r == S_OUT1) ? KIND_FIT : KIND_ASSIGN;
  assign out_ch.label    = (state_r == S_OUT1) ? 5'd0 : 5'({1'b0, bidx_r} + 1'b1);
  assign out_ch.distance = (state_r == S_OUT1) ? '0 : dist_r;
  assign out_ch.fitness  = (state_r == S_OUT1) ? fit_r : '0;
  assign out_ch.last     = (state_r == S_OUT1) || !last_r;
endmodule

@@ rtl/core/ncf_checker.sv @@
module ncf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kind,
  input logic out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_fit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last) else $error("fitness not last");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("in taken while out waits");
  a_fit_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_kind && !out_last |=> !in_ready)
    else $error("fitness skipped");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("in beat withdrawn");
endmodule

bind nearest_center_fitness_top ncf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.kind),
  .out_last(out_ch.last));
